/* sv/sm3_pkg.sv */
// sm3 hash engine package: constants, types and round functions
// no dependencies
package sm3_pkg;

   localparam int LengthBitsDefault = 64;
   localparam logic [31:0] TjLow  = 32'h79cc4519;
   localparam logic [31:0] TjHigh = 32'h7a879d8a;
   localparam logic [7:0]  PadMark = 8'h80;
   localparam int QueueDepth = 2;

   typedef logic [31:0] word_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        digest_last;
   } rsp_type;

   function automatic word_type iv_word(input logic [2:0] idx);
      word_type r;
      case (idx)
         3'd0: r = 32'h7380166f;
         3'd1: r = 32'h4914b2b9;
         3'd2: r = 32'h172442d7;
         3'd3: r = 32'hda8a0600;
         3'd4: r = 32'ha96f30bc;
         3'd5: r = 32'h163138aa;
         3'd6: r = 32'he38dee4d;
         default: r = 32'hb0fb0e4e;
      endcase
      return r;
   endfunction

   function automatic word_type rotl(input word_type x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   function automatic word_type perm0(input word_type x);
      return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
   endfunction

   function automatic word_type perm1(input word_type x);
      return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
   endfunction

endpackage

/* sv/sm3_if.sv */
// valid/ready channel interface carrying one payload
// payload type is a parameter, normally from sm3_pkg
interface sm3_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* sv/sm3_front.sv */
// front end: accepts request items into a short queue
// uses sm3_pkg and sm3_if
module sm3_front (
   input  logic            clock,
   input  logic            reset,
   sm3_if.sink             req,
   output sm3_pkg::req_type q_item,
   output logic            q_valid,
   input  logic            q_pop
);
   import sm3_pkg::*;

   req_type     mem_ff [QueueDepth];
   logic        wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push;

   assign req.ready = (cnt_ff != 2'(QueueDepth));
   assign push = req.valid && req.ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item = mem_ff[rd_ff];

   always_comb begin
      wr_in = push ? ~wr_ff : wr_ff;
      rd_in = (q_pop && q_valid) ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= req.payload;
      end
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(QueueDepth)) else $error("queue overflow");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'(QueueDepth) |-> !req.ready) else $error("ready while full");
   a_count: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop && cnt_ff == 2'd0) |=> cnt_ff == 2'd1) else $error("count");
`endif
endmodule

/* sv/sm3_back.sv */
// back end: absorbs bytes, pads, compresses and emits digest words
// uses sm3_pkg and sm3_if
module sm3_back #(
   parameter int LENGTH_COUNTER_BITS = sm3_pkg::LengthBitsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  sm3_pkg::req_type q_item,
   input  logic             q_valid,
   output logic             q_pop,
   sm3_if.source            rsp
);
   import sm3_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_PAD, S_COMP, S_OUT
   } state_type;

   state_type   state_ff;
   word_type    buf_ff [16];
   word_type    w_ff [16];
   word_type    cv_ff [8];
   word_type    a_ff, b_ff, c_ff, d_ff, e_ff, f_ff, g_ff, h_ff;
   logic [5:0]  fill_ff;
   logic [5:0]  pos_ff;
   logic [6:0]  rnd_ff;
   logic [LENGTH_COUNTER_BITS-1:0] len_ff;
   logic        final_ff, second_ff, padded_ff;
   logic [2:0]  oidx_ff;
   logic        ovalid_ff;

   word_type    tj, a12, ss1, ss2, ffv, ggv, tt1, tt2, wnew;
   logic [63:0] len64;
   logic [5:0]  rj;

   assign len64 = 64'(len_ff);
   assign rj = rnd_ff[5:0];
   assign tj = (rj < 6'd16) ? TjLow : TjHigh;
   assign a12 = rotl(a_ff, 5'd12);
   assign ss1 = rotl(a12 + e_ff + rotl(tj, rj[4:0]), 5'd7);
   assign ss2 = ss1 ^ a12;
   assign ffv = (rj < 6'd16) ? (a_ff ^ b_ff ^ c_ff)
                             : ((a_ff & b_ff) | (a_ff & c_ff) | (b_ff & c_ff));
   assign ggv = (rj < 6'd16) ? (e_ff ^ f_ff ^ g_ff) : ((e_ff & f_ff) | (~e_ff & g_ff));
   assign tt1 = ffv + d_ff + ss2 + (w_ff[0] ^ w_ff[4]);
   assign tt2 = ggv + h_ff + ss1 + w_ff[0];
   assign wnew = perm1(w_ff[0] ^ w_ff[7] ^ rotl(w_ff[13], 5'd15))
                 ^ rotl(w_ff[3], 5'd7) ^ w_ff[10];

   assign q_pop = (state_ff == S_IDLE) && q_valid;
   assign rsp.valid = ovalid_ff;
   assign rsp.payload.digest_word = cv_ff[oidx_ff];
   assign rsp.payload.word_index = oidx_ff;
   assign rsp.payload.digest_last = (oidx_ff == 3'd7);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff <= '0;
         len_ff <= '0;
         ovalid_ff <= 1'b0;
         oidx_ff <= '0;
         for (int i = 0; i < 8; i++) cv_ff[i] <= iv_word(3'(i));
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  final_ff <= q_item.last;
                  padded_ff <= 1'b0;
                  pos_ff <= q_item.byte_valid ? fill_ff + 6'd1 : fill_ff;
                  if (q_item.byte_valid) begin
                     buf_ff[fill_ff[5:2]][8*(3-fill_ff[1:0]) +: 8] <= q_item.data_byte;
                     len_ff <= len_ff + LENGTH_COUNTER_BITS'(8);
                     fill_ff <= fill_ff + 6'd1;
                  end
                  if (q_item.byte_valid && fill_ff == 6'd63) begin
                     second_ff <= 1'b0;
                     state_ff <= S_COMP;
                     rnd_ff <= '0;
                     for (int i = 0; i < 15; i++) w_ff[i] <= buf_ff[i];
                     w_ff[15] <= {buf_ff[15][31:8], q_item.data_byte};
                     {a_ff, b_ff, c_ff, d_ff} <= {cv_ff[0], cv_ff[1], cv_ff[2], cv_ff[3]};
                     {e_ff, f_ff, g_ff, h_ff} <= {cv_ff[4], cv_ff[5], cv_ff[6], cv_ff[7]};
                  end else if (q_item.last) begin
                     state_ff <= S_PAD;
                  end
               end
            end
            S_PAD: begin
               // pad from pos_ff, one or two blocks
               for (int i = 0; i < 64; i++) begin
                  if (6'(i) == pos_ff) buf_ff[i/4][8*(3-i%4) +: 8] <= PadMark;
                  else if (6'(i) > pos_ff) buf_ff[i/4][8*(3-i%4) +: 8] <= 8'h00;
               end
               second_ff <= (pos_ff > 6'd55);
               padded_ff <= 1'b1;
               for (int i = 0; i < 16; i++) begin
                  if (6'(i*4+3) == pos_ff) w_ff[i] <= {buf_ff[i][31:8], PadMark};
                  else if (6'(i*4+2) == pos_ff) w_ff[i] <= {buf_ff[i][31:16], PadMark, 8'h0};
                  else if (6'(i*4+1) == pos_ff) w_ff[i] <= {buf_ff[i][31:24], PadMark, 16'h0};
                  else if (6'(i*4) == pos_ff) w_ff[i] <= {PadMark, 24'h0};
                  else if (6'(i*4) > pos_ff) w_ff[i] <= 32'h0;
                  else w_ff[i] <= buf_ff[i];
               end
               if (pos_ff <= 6'd55) begin
                  w_ff[14] <= len64[63:32];
                  w_ff[15] <= len64[31:0];
               end
               rnd_ff <= '0;
               {a_ff, b_ff, c_ff, d_ff} <= {cv_ff[0], cv_ff[1], cv_ff[2], cv_ff[3]};
               {e_ff, f_ff, g_ff, h_ff} <= {cv_ff[4], cv_ff[5], cv_ff[6], cv_ff[7]};
               state_ff <= S_COMP;
            end
            S_COMP: begin
               if (rnd_ff == 7'd64) begin
                  cv_ff[0] <= cv_ff[0] ^ a_ff; cv_ff[1] <= cv_ff[1] ^ b_ff;
                  cv_ff[2] <= cv_ff[2] ^ c_ff; cv_ff[3] <= cv_ff[3] ^ d_ff;
                  cv_ff[4] <= cv_ff[4] ^ e_ff; cv_ff[5] <= cv_ff[5] ^ f_ff;
                  cv_ff[6] <= cv_ff[6] ^ g_ff; cv_ff[7] <= cv_ff[7] ^ h_ff;
                  if (second_ff) begin
                     second_ff <= 1'b0;
                     for (int i = 0; i < 14; i++) w_ff[i] <= 32'h0;
                     w_ff[14] <= len64[63:32];
                     w_ff[15] <= len64[31:0];
                     rnd_ff <= 7'd65;
                  end else if (final_ff && !padded_ff) begin
                     // last byte filled the block, padding block still to come
                     state_ff <= S_PAD;
                  end else if (final_ff) begin
                     state_ff <= S_OUT;
                     ovalid_ff <= 1'b1;
                     oidx_ff <= '0;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end else if (rnd_ff == 7'd65) begin
                  rnd_ff <= '0;
                  {a_ff, b_ff, c_ff, d_ff} <= {cv_ff[0], cv_ff[1], cv_ff[2], cv_ff[3]};
                  {e_ff, f_ff, g_ff, h_ff} <= {cv_ff[4], cv_ff[5], cv_ff[6], cv_ff[7]};
               end else begin
                  for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
                  w_ff[15] <= wnew;
                  d_ff <= c_ff; c_ff <= rotl(b_ff, 5'd9); b_ff <= a_ff; a_ff <= tt1;
                  h_ff <= g_ff; g_ff <= rotl(f_ff, 5'd19); f_ff <= e_ff; e_ff <= perm0(tt2);
                  rnd_ff <= rnd_ff + 7'd1;
               end
            end
            S_OUT: begin
               if (rsp.ready) begin
                  if (oidx_ff == 3'd7) begin
                     ovalid_ff <= 1'b0;
                     state_ff <= S_IDLE;
                     fill_ff <= '0;
                     len_ff <= '0;
                     for (int i = 0; i < 8; i++) cv_ff[i] <= iv_word(3'(i));
                  end
                  oidx_ff <= oidx_ff + 3'd1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_valid_out: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> state_ff == S_OUT) else $error("output outside digest state");
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == S_IDLE) else $error("pop while busy");
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COMP |-> rnd_ff <= 7'd65) else $error("round count");
`endif
endmodule

/* sv/sm3_hash_engine_core.sv */
// sm3 hash engine top level: front queue plus compression back end
// uses sm3_pkg, sm3_if, sm3_front, sm3_back
//
// One item carries at most one message byte; a byte is taken in while the back
// end is idle, and each full 64-byte block then runs through the round unit (load,
// 64 rounds, fold), during which no further bytes are taken. An item with last
// pads the message (one or two blocks) and then gives eight digest
// items, word 0 first. A two-entry queue in front lets bytes arrive while a
// block compresses.
module sm3_hash_engine_core #(
   parameter int LENGTH_COUNTER_BITS = sm3_pkg::LengthBitsDefault
) (
   input  logic clock,
   input  logic reset,
   sm3_if.sink  req,
   sm3_if.source rsp
);
   import sm3_pkg::*;

   req_type q_item;
   logic    q_valid, q_pop;

   sm3_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop)
   );

   sm3_back #(.LENGTH_COUNTER_BITS(LENGTH_COUNTER_BITS)) u_back (
      .clock(clock), .reset(reset), .q_item(q_item), .q_valid(q_valid),
      .q_pop(q_pop), .rsp(rsp)
   );
endmodule
